// File: src/trimmed_mean_window_filter_top_macros.svh
// Assertion macros shared by the trimmed-mean window filter RTL.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_TOP_MACROS_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, clocked and gated by reset.
`define TMWF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("tmwf assertion failed");
// Antecedent this cycle, consequent on the next.
`define TMWF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tmwf assertion failed");
`else
`define TMWF_ASSERT(lbl, clk, rstn, prop)
`define TMWF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/tmwf_pkg.sv
// Shared types and constants of the trimmed-mean window filter.
`timescale 1ns / 1ps

package tmwf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_LOAD
    } state_t;

    // Tags one read-data word of the window scan.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic live;     // entry has been written since reset
    } scan_t;

endpackage

// File: src/tmwf_store.sv
// Sample store: one write port, one registered read port.
`timescale 1ns / 1ps

module tmwf_store #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [tmwf_pkg::SAMPLE_W-1:0] rd_data
);

    logic [tmwf_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [tmwf_pkg::SAMPLE_W-1:0] rd_data_reg;

    // Writes and scan reads never hit the same cycle, so no bypass.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/tmwf_acc.sv
// Window scan accumulator: running sum, largest and smallest sample.
`timescale 1ns / 1ps
`include "trimmed_mean_window_filter_top_macros.svh"

module tmwf_acc #(
    parameter int SW = 21
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tmwf_pkg::scan_t               scan,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] rd_data,
    output logic                          done,
    output logic signed [SW-1:0]          trim
);

    localparam int XW = SW - tmwf_pkg::SAMPLE_W;

    logic signed [SW-1:0]                 sum_reg, sum_next;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] hi_reg, hi_next;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] lo_reg, lo_next;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] elem;
    logic signed [SW-1:0]                 elem_x, hi_x, lo_x;
    logic                                 done_reg;

    // never-written entries count as zero
    assign elem   = scan.live ? $signed(rd_data) : '0;
    assign elem_x = {{XW{elem[tmwf_pkg::SAMPLE_W-1]}}, elem};
    assign hi_x   = {{XW{hi_reg[tmwf_pkg::SAMPLE_W-1]}}, hi_reg};
    assign lo_x   = {{XW{lo_reg[tmwf_pkg::SAMPLE_W-1]}}, lo_reg};

    always_comb begin
        sum_next = sum_reg;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        if (scan.valid) begin
            if (scan.first) begin
                sum_next = elem_x;
                hi_next  = elem;
                lo_next  = elem;
            end else begin
                sum_next = sum_reg + elem_x;
                if (elem > hi_reg) begin
                    hi_next = elem;
                end
                if (elem < lo_reg) begin
                    lo_next = elem;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= scan.valid && scan.last;
        end
    end

    assign done = done_reg;
    assign trim = sum_reg - hi_x - lo_x;

    `TMWF_ASSERT(a_hi_not_below_lo, aclk, aresetn, (scan.valid && !scan.first) |-> hi_reg >= lo_reg)

endmodule

// File: src/tmwf_div.sv
// Signed divide by a constant, truncating toward zero, three stages.
`timescale 1ns / 1ps

module tmwf_div #(
    parameter int SW      = 21,
    parameter int DIVISOR = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic signed [SW-1:0]          in_data,
    output logic                          out_valid,
    output logic [tmwf_pkg::SAMPLE_W-1:0] out_data
);

    // floor(n / D) = (n * M) >> S for every n below 2**SW
    localparam int          L     = $clog2(DIVISOR);
    localparam int          S     = SW + L;
    localparam int          MW    = SW + 1;
    localparam int          PRW   = SW + MW;
    localparam logic [63:0] M64   = ((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = M64[MW-1:0];

    logic                          v1_reg, v2_reg, v3_reg;
    logic                          neg1_reg, neg2_reg;
    logic [SW-1:0]                 mag_reg;
    logic [PRW-1:0]                prod_reg;
    logic [tmwf_pkg::SAMPLE_W-1:0] quot;
    logic [tmwf_pkg::SAMPLE_W-1:0] res_reg;

    assign quot = prod_reg[S +: tmwf_pkg::SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            neg1_reg <= in_data[SW-1];
            mag_reg  <= in_data[SW-1] ? SW'(-in_data) : SW'(in_data);
        end
        if (v1_reg) begin
            neg2_reg <= neg1_reg;
            prod_reg <= PRW'(mag_reg) * PRW'(RECIP);
        end
        if (v2_reg) begin
            res_reg <= neg2_reg ? -quot : quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res_reg;

endmodule

// File: src/trimmed_mean_window_filter_top.sv
// Top level of the multi-channel trimmed-mean window filter.
`timescale 1ns / 1ps
`include "trimmed_mean_window_filter_top_macros.svh"

// Each input transaction carries one signed 16-bit sample (s_tdata) and a
// channel number (s_tuser, reduced modulo CHANNELS). The sample overwrites the
// oldest of that channel's WINDOW stored samples; the block then returns one
// result: the sum of the channel's window minus one copy of its largest and
// one of its smallest sample, divided by WINDOW-2 and truncated toward zero.
// After reset every window reads as zeros; a per-channel fill flag masks
// entries not yet written, so no clearing pass is needed and the block is
// ready straight out of reset. One transaction is processed at a time: the
// window scan reads the sample store through its single read port, one entry
// per cycle, followed by the three-stage reciprocal divider. The result sits
// in an output register, so a new sample is accepted while the previous
// result still waits on m_tready.

module trimmed_mean_window_filter_top #(
    parameter int WINDOW   = 12,
    parameter int CHANNELS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tmwf_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic [tmwf_pkg::CHAN_W-1:0]   s_tuser,   // [1:0] channel
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmwf_pkg::SAMPLE_W-1:0] m_tdata    // [15:0] filtered
);

    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int AW      = $clog2(DEPTH);
    localparam int PW      = $clog2(WINDOW);
    localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW      = 17 + $clog2(WINDOW);   // signed window sum
    localparam int DIVISOR = WINDOW - 2;

    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
    localparam logic [4:0]    CH_COUNT = 5'(CHANNELS);

    tmwf_pkg::state_t state_reg, state_next;

    logic [PW-1:0]       wpos_reg [CHANNELS];  // next write slot per channel
    logic [CHANNELS-1:0] full_reg;             // window wrapped at least once

    logic [4:0]          ch_wide;
    logic [CHW-1:0]      ch_sel;
    logic [PW-1:0]       wp_cur;
    logic                full_cur;
    logic                pos_wrap;
    logic [AW-1:0]       base_cur;
    logic [AW-1:0]       wr_addr;
    logic                accept;

    // scan of the current transaction
    logic [AW-1:0]       base_reg;
    logic [PW-1:0]       lim_reg;              // slot just written
    logic                fill_reg;             // whole window written
    logic [PW-1:0]       k_reg;
    tmwf_pkg::scan_t     scan_reg;
    logic [AW-1:0]       rd_addr;
    logic [tmwf_pkg::SAMPLE_W-1:0] rd_data;

    logic                acc_done;
    logic signed [SW-1:0] acc_trim;
    logic                div_valid;
    logic [tmwf_pkg::SAMPLE_W-1:0] div_data;

    logic                scan_issue;
    logic                load_en;
    logic                m_tvalid_reg;
    logic [tmwf_pkg::SAMPLE_W-1:0] m_tdata_reg;

    // channel modulo CHANNELS, at most three subtractions on a 2-bit value
    always_comb begin
        ch_wide = {3'b000, s_tuser};
        for (int i = 0; i < 3; i++) begin
            if (ch_wide >= CH_COUNT) begin
                ch_wide = ch_wide - CH_COUNT;
            end
        end
    end

    assign ch_sel   = ch_wide[CHW-1:0];
    assign wp_cur   = wpos_reg[ch_sel];
    assign full_cur = full_reg[ch_sel];
    assign pos_wrap = (wp_cur == POS_LAST);
    assign base_cur = AW'(ch_sel) * AW'(WINDOW);
    assign wr_addr  = base_cur + AW'(wp_cur);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = base_reg + AW'(k_reg);

    // ---- control FSM ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmwf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tmwf_pkg::ST_SCAN;
                end
            end
            tmwf_pkg::ST_SCAN: begin
                if (k_reg == POS_LAST) begin
                    state_next = tmwf_pkg::ST_WAIT;
                end
            end
            tmwf_pkg::ST_WAIT: begin
                if (div_valid) begin
                    state_next = tmwf_pkg::ST_LOAD;
                end
            end
            tmwf_pkg::ST_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = tmwf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tmwf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        scan_issue = 1'b0;
        load_en    = 1'b0;
        case (state_reg)
            tmwf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            tmwf_pkg::ST_SCAN: begin
                scan_issue = 1'b1;
            end
            tmwf_pkg::ST_LOAD: begin
                load_en = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmwf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---- per-channel write pointers and fill flags ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                wpos_reg[c] <= '0;
            end
            full_reg <= '0;
        end else if (accept) begin
            wpos_reg[ch_sel] <= pos_wrap ? '0 : wp_cur + 1'b1;
            if (pos_wrap) begin
                full_reg[ch_sel] <= 1'b1;
            end
        end
    end

    // transaction context, captured on acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            base_reg <= base_cur;
            lim_reg  <= wp_cur;
            fill_reg <= full_cur || pos_wrap;
        end
    end

    // scan counter and tag for the word coming back from the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= '0;
            scan_reg <= '0;
        end else begin
            if (accept) begin
                k_reg <= '0;
            end else if (scan_issue) begin
                k_reg <= (k_reg == POS_LAST) ? '0 : k_reg + 1'b1;
            end
            scan_reg.valid <= scan_issue;
            scan_reg.first <= (k_reg == '0);
            scan_reg.last  <= (k_reg == POS_LAST);
            scan_reg.live  <= fill_reg || (k_reg <= lim_reg);
        end
    end

    tmwf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tmwf_acc #(
        .SW (SW)
    ) u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scan    (scan_reg),
        .rd_data (rd_data),
        .done    (acc_done),
        .trim    (acc_trim)
    );

    tmwf_div #(
        .SW      (SW),
        .DIVISOR (DIVISOR)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_done),
        .in_data   (acc_trim),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            m_tdata_reg <= div_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TMWF_ASSERT(a_div_only_when_waiting, aclk, aresetn, div_valid |-> state_reg == tmwf_pkg::ST_WAIT)
    `TMWF_ASSERT(a_wpos_in_window, aclk, aresetn, wp_cur <= POS_LAST)
    `TMWF_ASSERT_NEXT(a_scan_tags_last, aclk, aresetn, (state_reg == tmwf_pkg::ST_SCAN && k_reg == POS_LAST), (scan_reg.valid && scan_reg.last))

endmodule

// File: dv/tb_trimmed_mean_window_filter_top.sv
// Self-checking stream testbench for the multi-channel trimmed-mean window filter.
`timescale 1ns / 1ps

module tb_trimmed_mean_window_filter_top;

    localparam int SAMPLE_W = tmwf_pkg::SAMPLE_W;
    localparam int CHAN_W   = tmwf_pkg::CHAN_W;

    // Geometry of the block as instantiated (defaults).
    localparam int WIN        = 12;
    localparam int CHN        = 4;
    // Allow a wide margin over the per-item cost of the slowest run.
    localparam int DRAIN_WAIT = 60;
    localparam int CYCLE_CAP  = 200000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;   // [15:0] sample
    logic [CHAN_W-1:0]   s_tuser;   // [1:0] channel
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;   // [15:0] filtered

    // Shadow of the block's sample store and per-channel write pointers.
    logic signed [SAMPLE_W-1:0] win_store [CHN][WIN];
    int unsigned                wr_pos    [CHN];

    // Filtered values still owed by the block, oldest first.
    logic [SAMPLE_W-1:0] filtered_due [$];
    logic [SAMPLE_W-1:0] due_value;

    int  mismatch_count;
    int  cycle_count;
    bit  src_idle_en;       // random gaps between input transactions
    bit  sink_idle_en;      // random m_tready drops
    int  sink_hold;         // one-off long hold-off on the result side, in cycles

    trimmed_mean_window_filter_top #(
        .WINDOW   (WIN),
        .CHANNELS (CHN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Writes the sample into the shadow window, advances the channel pointer
    // and returns the trimmed mean: sum less one max and one min, over WIN-2,
    // truncated toward zero (plain int division does exactly that).
    function automatic logic [SAMPLE_W-1:0] advance_window(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [CHAN_W-1:0]          ch
    );
        int idx;
        int k;
        int acc;
        int top;
        int bot;
        int e;
        idx = ch % CHN;
        win_store[idx][wr_pos[idx]] = smp;
        top = win_store[idx][0];
        bot = top;
        acc = top;
        for (k = 1; k < WIN; k++) begin
            e   = win_store[idx][k];
            acc = acc + e;
            if (e > top)
                top = e;
            else if (e < bot)
                bot = e;
        end
        wr_pos[idx] = (wr_pos[idx] == WIN - 1) ? 0 : wr_pos[idx] + 1;
        acc = acc - top - bot;
        return SAMPLE_W'(acc / (WIN - 2));
    endfunction

    // Offers one transaction and holds it until accepted. Entered just after a
    // rising edge; the expected result is queued at the accepting edge.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [CHAN_W-1:0]          ch
    );
        int bursts;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        do @(posedge aclk); while (!s_tready);
        filtered_due.push_back(advance_window(smp, ch));
        // Gaps are strings of short bursts so that they land on every phase
        // of the block's scan, not only inside its busy window.
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            bursts = $urandom_range(1, 8);
            repeat (bursts) repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Drops s_tvalid and waits until every owed result has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (filtered_due.size() != 0) @(posedge aclk);
    endtask

    // Mostly full-range values, with extremes and a narrow band near zero so
    // that ties on the largest and smallest value turn up often.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    // Runs of random length on one channel, so windows fill and wrap.
    task automatic send_random_runs(input int n_items);
        int sent;
        int run;
        logic [CHAN_W-1:0] ch;
        sent = 0;
        while (sent < n_items) begin
            ch  = CHAN_W'($urandom_range(0, CHN - 1));
            run = $urandom_range(1, 14);
            repeat (run) begin
                send_sample(pick_sample(), ch);
                sent++;
            end
        end
    endtask

    // Start-up: zeros still in the window, field extremes on channel 0, then
    // one transaction on every other channel.
    task automatic test_startup_extremes();
        send_sample(16'sh7FFF, 2'd0);
        send_sample(16'sh8000, 2'd0);
        send_sample(-16'sd1, 2'd0);
        send_sample(16'sd1, 2'd0);
        send_sample(16'sh5555, 2'd0);
        send_sample(16'shAAAA, 2'd1);
        send_sample(16'sh7FFF, 2'd2);
        send_sample(16'sh8000, 2'd3);
    endtask

    // Ties: a full window of the most negative value (wraps the pointer too),
    // and two copies of the maximum among zeros.
    task automatic test_ties();
        repeat (WIN) send_sample(16'sh8000, 2'd2);
        send_sample(16'sh7FFF, 2'd3);
        send_sample(16'sh7FFF, 2'd3);
        wait_for_results();
    endtask

    task automatic test_random_idling();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_random_runs(400);
    endtask

    // Long result-side hold-off while the sender keeps offering: the output
    // register fills and s_tready has to fall.
    task automatic test_backpressure();
        int i;
        src_idle_en = 1'b0;
        sink_hold   = 300;
        for (i = 0; i < 8; i++)
            send_sample(pick_sample(), CHAN_W'(i % CHN));
        wait_for_results();
        src_idle_en = 1'b1;
    endtask

    // Sender drains the block fully, pauses, then resumes mid-window.
    task automatic test_drain_pause();
        send_random_runs(20);
        wait_for_results();
        repeat ($urandom_range(1, 3)) @(posedge aclk);
        send_random_runs(20);
        wait_for_results();
    endtask

    // Last stretch: back-to-back on both sides.
    task automatic test_random_streaming();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_runs(380);
    endtask

    // Result side: m_tready driven from its own process.
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold != 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
                m_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every accepted result transaction is matched against the oldest owed value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                due_value = filtered_due.pop_front();
                if (m_tdata !== due_value)
                    report_mismatch($sformatf("filtered %h, want %h", m_tdata, due_value));
            end
        end
    end

    initial begin : stimulus
        int c;
        int k;
        mismatch_count = 0;
        src_idle_en    = 1'b0;
        sink_idle_en   = 1'b0;
        sink_hold      = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        for (c = 0; c < CHN; c++) begin
            wr_pos[c] = 0;
            for (k = 0; k < WIN; k++)
                win_store[c][k] = '0;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_startup_extremes();
        test_ties();
        test_random_idling();
        test_backpressure();
        test_drain_pause();
        test_random_streaming();

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && filtered_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/tmwf_pkg.sv
src/tmwf_store.sv
src/tmwf_acc.sv
src/tmwf_div.sv
src/trimmed_mean_window_filter_top.sv
dv/tb_trimmed_mean_window_filter_top.sv
